// ----- rtl/kst_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the spanning tree block
// no dependencies
package kst_pkg;
  localparam int VTX_W = 6;
  localparam int WGT_W = 16;
  localparam int CFG_W = 7;

  typedef struct packed {
    logic [VTX_W-1:0]        src;
    logic [VTX_W-1:0]        dst;
    logic signed [WGT_W-1:0] weight;
  } edge_t;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_RUN
  } state_t;
endpackage

// ----- rtl/kst_sort_cell.sv -----
`timescale 1ns / 1ps
// one slot of the insertion sort chain, holds one edge
// depends on kst_pkg
module kst_sort_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          ins,
  input  logic          pop,
  input  kst_pkg::edge_t new_edge,
  input  kst_pkg::edge_t prev_edge,
  input  logic          prev_valid,
  input  logic          prev_gt,
  input  kst_pkg::edge_t succ_edge,
  input  logic          succ_valid,
  output kst_pkg::edge_t edge_q,
  output logic          valid_q,
  output logic          gt
);
  import kst_pkg::*;

  edge_t edge_r, edge_nxt;
  logic  valid_r, valid_nxt;

  // greater than the incoming edge: equal weights stay ahead (stable)
  assign gt = !valid_r || (edge_r.weight > new_edge.weight);

  always_comb begin
    edge_nxt  = edge_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (ins) begin
      if (prev_gt) begin
        edge_nxt  = prev_edge;
        valid_nxt = prev_valid;
      end else if (gt) begin
        edge_nxt  = new_edge;
        valid_nxt = 1'b1;
      end
    end else if (pop) begin
      edge_nxt  = succ_edge;
      valid_nxt = succ_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    edge_r <= edge_nxt;
  end

  assign edge_q  = edge_r;
  assign valid_q = valid_r;
endmodule

// ----- rtl/kst_vertex_cell.sv -----
`timescale 1ns / 1ps
// one vertex of the set tracker, holds the label of its component
// no dependencies
module kst_vertex_cell #(
  parameter int LW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          init,
  input  logic          merge,
  input  logic [LW-1:0] from_lbl,
  input  logic [LW-1:0] to_lbl,
  output logic [LW-1:0] lbl
);
  logic [LW-1:0] lbl_r, lbl_nxt;

  always_comb begin
    lbl_nxt = lbl_r;
    if (init) begin
      lbl_nxt = LW'(IDX);
    end else if (merge && (lbl_r == from_lbl)) begin
      lbl_nxt = to_lbl;
    end
  end

  always_ff @(posedge clk) begin
    lbl_r <= lbl_nxt;
  end

  assign lbl = lbl_r;
endmodule

// ----- rtl/kruskal_spanning_tree.sv -----
`timescale 1ns / 1ps
// kruskal spanning tree: sorted edge chain plus per-vertex component labels
// load: one edge beat per cycle, inserted in weight order as it arrives
// run: one sorted edge examined per cycle while the output is not stalled; each
//   tree edge is held until the next one is found or the run ends, so the final
//   one can be marked; input stalls for the whole run, which output stalls extend
// sync active-low reset empties the chain and sets vertex_count to 64
module kruskal_spanning_tree #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_enable,
  input  logic [kst_pkg::CFG_W-1:0]     cfg_vertex_count,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kst_pkg::VTX_W-1:0]     in_from_vertex,
  input  logic [kst_pkg::VTX_W-1:0]     in_to_vertex,
  input  logic signed [kst_pkg::WGT_W-1:0] in_edge_weight,
  input  logic                          in_last_input,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kst_pkg::VTX_W-1:0]     out_mst_from,
  output logic [kst_pkg::VTX_W-1:0]     out_mst_to,
  output logic signed [kst_pkg::WGT_W-1:0] out_mst_weight,
  output logic                          out_last_edge,
  output logic                          out_overflow
);
  import kst_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_EDGES + 1);

  state_t state_r, state_nxt;
  logic [CFG_W-1:0] vcount_r;
  logic [CW-1:0]    ecount_r, ecount_nxt;
  logic             dropped_r, dropped_nxt;
  logic [CFG_W-1:0] acc_r, acc_nxt;
  edge_t            pend_r, pend_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  edge_t            out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  // vertex count in use, saturated to the build size
  logic [CFG_W-1:0] nv, limit;
  assign nv    = (vcount_r > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_r;
  assign limit = (nv == '0) ? '0 : nv - CFG_W'(1);

  // input side
  edge_t in_edge;
  logic  in_acc, in_ok;
  assign in_edge  = '{src: in_from_vertex, dst: in_to_vertex, weight: in_edge_weight};
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign in_ok    = ({1'b0, in_from_vertex} < nv) && ({1'b0, in_to_vertex} < nv)
                    && (ecount_r != CW'(MAX_EDGES));

  // sort chain
  edge_t cell_edge [MAX_EDGES];
  logic  cell_valid [MAX_EDGES];
  logic  cell_gt [MAX_EDGES];
  logic  chain_ins, chain_pop, chain_clear;
  assign chain_ins = in_acc && in_ok;

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_sort
    edge_t p_edge, n_edge;
    logic  p_valid, p_gt, n_valid;
    if (i == 0) begin : g_head
      assign p_edge  = in_edge;
      assign p_valid = 1'b0;
      assign p_gt    = 1'b0;
    end else begin : g_mid
      assign p_edge  = cell_edge[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_gt    = cell_gt[i-1];
    end
    if (i == MAX_EDGES - 1) begin : g_tail
      assign n_edge  = in_edge;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_edge  = cell_edge[i+1];
      assign n_valid = cell_valid[i+1];
    end
    kst_sort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clear      (chain_clear),
      .ins        (chain_ins),
      .pop        (chain_pop),
      .new_edge   (in_edge),
      .prev_edge  (p_edge),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .succ_edge  (n_edge),
      .succ_valid (n_valid),
      .edge_q     (cell_edge[i]),
      .valid_q    (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

  // vertex label cells: same label means same component
  logic [VW-1:0] lbl [MAX_VERTICES];
  logic [VW-1:0] la, lb;
  logic          lbl_init, lbl_merge;
  assign lbl_init = in_acc && in_last_input;

  for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_vtx
    kst_vertex_cell #(.LW(VW), .IDX(v)) u_vtx (
      .clk      (clk),
      .init     (lbl_init),
      .merge    (lbl_merge),
      .from_lbl (la),
      .to_lbl   (lb),
      .lbl      (lbl[v])
    );
  end

  edge_t head;
  logic  head_valid, head_rng, head_join, finish, out_free;
  assign head       = cell_edge[0];
  assign head_valid = cell_valid[0];
  assign head_rng   = ({1'b0, head.src} < nv) && ({1'b0, head.dst} < nv);
  assign la         = lbl[head.src[VW-1:0]];
  assign lb         = lbl[head.dst[VW-1:0]];
  assign head_join  = head_rng && (la != lb);
  assign finish     = !head_valid || (acc_r == limit);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    ecount_nxt     = ecount_r;
    dropped_nxt    = dropped_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    chain_pop      = 1'b0;
    chain_clear    = 1'b0;
    lbl_merge      = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_ok) begin
            ecount_nxt = ecount_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last_input) begin
            acc_nxt        = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          if (finish) begin
            // flush the held edge as the final one and reset for next graph
            if (pend_valid_r) begin
              out_nxt       = pend_r;
              out_last_nxt  = 1'b1;
              out_ovf_nxt   = dropped_r;
              out_valid_nxt = 1'b1;
            end
            pend_valid_nxt = 1'b0;
            chain_clear    = 1'b1;
            ecount_nxt     = '0;
            dropped_nxt    = 1'b0;
            state_nxt      = ST_LOAD;
          end else begin
            chain_pop = 1'b1;
            if (head_join) begin
              lbl_merge = 1'b1;
              acc_nxt   = acc_r + CFG_W'(1);
              if (pend_valid_r) begin
                out_nxt       = pend_r;
                out_last_nxt  = 1'b0;
                out_ovf_nxt   = dropped_r;
                out_valid_nxt = 1'b1;
              end
              pend_nxt       = head;
              pend_valid_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      vcount_r     <= CFG_W'(64);
      ecount_r     <= '0;
      dropped_r    <= 1'b0;
      acc_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_write_enable) begin
        vcount_r <= cfg_vertex_count;
      end
      ecount_r     <= ecount_nxt;
      dropped_r    <= dropped_nxt;
      acc_r        <= acc_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_mst_from   = out_r.src;
  assign out_mst_to     = out_r.dst;
  assign out_mst_weight = out_r.weight;
  assign out_last_edge  = out_last_r;
  assign out_overflow   = out_ovf_r;
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for the kruskal spanning tree block
// depends on kst_pkg and kruskal_spanning_tree
module testbench;
  import kst_pkg::*;

  localparam int NV_MAX   = 64;
  localparam int EDGE_CAP = 256;
  localparam int WATCHDOG = 200000;

  // one tree edge as it leaves the block
  typedef struct {
    logic [VTX_W-1:0]        src;
    logic [VTX_W-1:0]        dst;
    logic signed [WGT_W-1:0] weight;
    logic                    last;
    logic                    ovf;
  } tree_edge_t;

  // one directed stimulus row with the vertex count it runs under
  typedef struct {
    logic [CFG_W-1:0]        vcount;
    logic [VTX_W-1:0]        src;
    logic [VTX_W-1:0]        dst;
    logic signed [WGT_W-1:0] weight;
    logic                    last;
  } edge_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_enable = 1'b0;
  logic [CFG_W-1:0] cfg_vertex_count = 7'd64;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VTX_W-1:0] in_from_vertex = '0;
  logic [VTX_W-1:0] in_to_vertex = '0;
  logic signed [WGT_W-1:0] in_edge_weight = '0;
  logic in_last_input = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VTX_W-1:0] out_mst_from;
  logic [VTX_W-1:0] out_mst_to;
  logic signed [WGT_W-1:0] out_mst_weight;
  logic out_last_edge;
  logic out_overflow;

  kruskal_spanning_tree dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_vertex_count (cfg_vertex_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_edge_weight   (in_edge_weight),
    .in_last_input    (in_last_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mst_from     (out_mst_from),
    .out_mst_to       (out_mst_to),
    .out_mst_weight   (out_mst_weight),
    .out_last_edge    (out_last_edge),
    .out_overflow     (out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the block's graph state
  logic [CFG_W-1:0]        vcount_reg;
  logic [VTX_W-1:0]        graph_src [EDGE_CAP];
  logic [VTX_W-1:0]        graph_dst [EDGE_CAP];
  logic signed [WGT_W-1:0] graph_wgt [EDGE_CAP];
  int                      graph_len;
  bit                      graph_dropped;

  tree_edge_t expected_tree[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  // gap lengths: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int find_root(ref int link[NV_MAX], input int v);
    int hops;
    for (hops = 0; hops < NV_MAX; hops++) begin
      if (link[v] == v) break;
      v = link[v];
    end
    return v;
  endfunction

  // load one edge; on the graph's last beat grow the spanning forest
  task automatic predict_tree(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] d,
                              input logic signed [WGT_W-1:0] w, input logic last);
    int nv, limit, taken, i, j, k, ra, rb;
    int order[EDGE_CAP];
    int link[NV_MAX];
    tree_edge_t te;
    tree_edge_t found[$];
    nv = (vcount_reg > NV_MAX) ? NV_MAX : vcount_reg;
    if (s >= nv || d >= nv || graph_len >= EDGE_CAP) begin
      graph_dropped = 1'b1;
    end else begin
      graph_src[graph_len] = s;
      graph_dst[graph_len] = d;
      graph_wgt[graph_len] = w;
      graph_len++;
    end
    if (!last) return;
    // stable insertion sort by signed weight
    for (i = 0; i < graph_len; i++) begin
      j = i;
      while (j > 0 && graph_wgt[order[j-1]] > graph_wgt[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < NV_MAX; i++) link[i] = i;
    limit = (nv > 0) ? nv - 1 : 0;
    taken = 0;
    for (i = 0; i < graph_len && taken < limit; i++) begin
      k = order[i];
      // edges stale under a lowered vertex count are skipped
      if (graph_src[k] >= nv || graph_dst[k] >= nv) continue;
      ra = find_root(link, graph_src[k]);
      rb = find_root(link, graph_dst[k]);
      if (ra != rb) begin
        te.src = graph_src[k];
        te.dst = graph_dst[k];
        te.weight = graph_wgt[k];
        te.last = 1'b0;
        te.ovf = graph_dropped;
        found = {found, te};
        link[ra] = rb;
        taken++;
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[n]) expected_tree = {expected_tree, found[n]};
    graph_len = 0;
    graph_dropped = 1'b0;
  endtask

  // drive one edge beat and hold it until taken; valid stays up for back to back beats
  task automatic send_edge(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] d,
                           input logic signed [WGT_W-1:0] w, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_from_vertex <= s;
    in_to_vertex <= d;
    in_edge_weight <= w;
    in_last_input <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tree(s, d, w, last);
  endtask

  // register writes happen only once the block has drained
  task automatic set_vertex_count(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_tree.size() > 0) @(posedge clk);
    // a run that finds no tree edge may still be busy: allow its walk
    repeat (EDGE_CAP + 8) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_vertex_count <= v;
    vcount_reg = v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // random graph: mostly legal endpoints, a few bad ones
  task automatic send_graph(input int nedges);
    int nv, i;
    logic [VTX_W-1:0] s, d;
    logic signed [WGT_W-1:0] w;
    nv = (vcount_reg > NV_MAX) ? NV_MAX : vcount_reg;
    for (i = 0; i < nedges; i++) begin
      if (nv == 0 || $urandom_range(0, 19) == 0) begin
        s = VTX_W'($urandom);
        d = VTX_W'($urandom);
      end else begin
        s = VTX_W'($urandom_range(0, nv - 1));
        d = VTX_W'($urandom_range(0, nv - 1));
      end
      case ($urandom_range(0, 3))
        0: w = WGT_W'($urandom_range(0, 7));  // many ties
        1: w = -$signed({1'b0, 15'($urandom_range(0, 7))});
        default: w = WGT_W'($urandom);
      endcase
      send_edge(s, d, w, i == nedges - 1);
    end
  endtask

  // directed table: extremes, self loop, bad endpoint, ties, one-edge graph
  edge_row_t directed[] = '{
    '{7'd64, 6'd0,  6'd63, 16'sh7fff, 1'b0},
    '{7'd64, 6'd63, 6'd0,  16'sh8000, 1'b0},
    '{7'd64, 6'd5,  6'd5,  16'sh8000, 1'b0},  // self loop
    '{7'd64, 6'd1,  6'd2,  16'sh0003, 1'b0},
    '{7'd64, 6'd2,  6'd1,  16'sh0003, 1'b1},
    '{7'd4,  6'd0,  6'd1,  16'sh0001, 1'b0},
    '{7'd4,  6'd3,  6'd60, 16'sh0000, 1'b0},  // bad endpoint, sets overflow
    '{7'd4,  6'd1,  6'd2,  16'sh0001, 1'b0},
    '{7'd4,  6'd2,  6'd3,  16'sh0001, 1'b0},
    '{7'd4,  6'd0,  6'd3,  16'shffff, 1'b1},
    '{7'd4,  6'd5,  6'd6,  16'sh0002, 1'b1},  // bad last edge: empty run
    '{7'd1,  6'd0,  6'd0,  16'sh0004, 1'b1},  // one vertex: nothing to join
    '{7'd2,  6'd1,  6'd0,  16'sh1234, 1'b1},
    '{7'd0,  6'd0,  6'd0,  16'sh0001, 1'b1},  // zero vertices: all dropped
    '{7'd127, 6'd62, 6'd63, 16'sh0009, 1'b0}, // saturated count
    '{7'd127, 6'd63, 6'd61, 16'sh0008, 1'b1}
  };

  // stall the result side at random
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (1 + gap_len()) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // compare each tree edge beat with the oldest expectation
  always @(posedge clk) begin
    tree_edge_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tree.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tree edge %0d-%0d w=%0d", out_mst_from, out_mst_to,
                   out_mst_weight);
      end else begin
        e = expected_tree.pop_front();
        if (out_mst_from !== e.src || out_mst_to !== e.dst || out_mst_weight !== e.weight
            || out_last_edge !== e.last || out_overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tree edge mismatch: exp %0d-%0d w=%0d l=%0b o=%0b got %0d-%0d w=%0d l=%0b o=%0b",
                     e.src, e.dst, e.weight, e.last, e.ovf, out_mst_from, out_mst_to,
                     out_mst_weight, out_last_edge, out_overflow);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int i, j, reps, sent, prev_count, wait_cycles;
    logic [CFG_W-1:0] cfg_choice[] = '{7'd64, 7'd2, 7'd8, 7'd17, 7'd33, 7'd127, 7'd1};
    vcount_reg = 7'd64;
    graph_len = 0;
    graph_dropped = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_count = 64;
    foreach (directed[r]) begin
      if (directed[r].vcount != prev_count) begin
        set_vertex_count(directed[r].vcount);
        prev_count = directed[r].vcount;
      end
      send_edge(directed[r].src, directed[r].dst, directed[r].weight, directed[r].last);
    end

    // lowered count after loading: stale stored edges get skipped at run time
    set_vertex_count(7'd10);
    send_edge(6'd8, 6'd9, 16'sh0001, 1'b0);
    send_edge(6'd1, 6'd2, 16'sh0002, 1'b0);
    set_vertex_count(7'd5);
    send_edge(6'd3, 6'd4, 16'sh0003, 1'b1);

    // store full: more edges than the store holds, in one graph at the full vertex count
    set_vertex_count(7'd64);
    for (i = 0; i < EDGE_CAP + 2; i++)
      send_edge(VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom), i == EDGE_CAP + 1);

    // random graphs under several vertex counts
    sent = 0;
    while (sent < 85) begin
      set_vertex_count(cfg_choice[$urandom_range(0, cfg_choice.size() - 1)]);
      reps = $urandom_range(2, 5);
      for (j = 0; j < reps && sent < 85; j++) begin
        i = $urandom_range(1, 14);
        send_graph(i);
        sent += i;
      end
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_tree.size() > 0 && wait_cycles < WATCHDOG) begin
      @(posedge clk);
      wait_cycles++;
    end
    stim_done = 1'b1;
    repeat (EDGE_CAP + 20) @(posedge clk);
    if (mismatches == 0 && expected_tree.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
